/* hw/rtl/sapw_pkg.sv */
// Shared types and constants for the scissored alpha blend pixel write unit.
`timescale 1ns / 1ps

package sapw_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    // Field widths.
    localparam int DIM_W   = 13;
    localparam int EDGE_W  = 12;
    localparam int EXTENT_W = 14;
    localparam int INDEX_W = 24;

    // Register reset values.
    localparam logic [DIM_W-1:0] BUFFER_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] BUFFER_HEIGHT_RESET = 13'd480;

    // Blend arithmetic constants.
    localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
    localparam logic [15:0] ROUND_BIAS  = 16'd127;
    // Reciprocal of 255 scaled by 2^23; exact for every blend sum below 2^16.
    localparam logic [15:0] RECIP_255   = 16'h8081;
    localparam int          RECIP_SHIFT = 23;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BUFFER_WIDTH   = 3'd0,
        REG_BUFFER_HEIGHT  = 3'd1,
        REG_SCISSOR_ENABLE = 3'd2,
        REG_SCISSOR_LEFT   = 3'd3,
        REG_SCISSOR_TOP    = 3'd4,
        REG_SCISSOR_WIDTH  = 3'd5,
        REG_SCISSOR_HEIGHT = 3'd6
    } cfg_reg_t;

    // One pixel request.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         src_blue;
        logic [7:0]         src_green;
        logic [7:0]         src_red;
        logic [7:0]         src_alpha;
        logic [7:0]         dst_blue;
        logic [7:0]         dst_green;
        logic [7:0]         dst_red;
    } pixel_req_t;

    // One pixel write result.
    typedef struct packed {
        logic               write_enable;
        logic [INDEX_W-1:0] pixel_index;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
    } pixel_wr_t;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } stage_load_t;

endpackage

/* hw/rtl/sapw_pixel_if.sv */
// Request channel carrying pixel requests into the write unit.
`timescale 1ns / 1ps

interface sapw_pixel_if
    import sapw_pkg::*;
();
    logic       valid;
    logic       ready;
    pixel_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sapw_result_if.sv */
// Result channel carrying pixel write results out of the write unit.
`timescale 1ns / 1ps

interface sapw_result_if
    import sapw_pkg::*;
();
    logic      valid;
    logic      ready;
    pixel_wr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/scissored_alpha_blend_pixel_write_top.sv */
// Top level of the scissored alpha blend pixel write unit.
// Throughput: one request per cycle; a stalled result holds the pipeline in place.
// The index product and the blend reciprocal multiply each occupy one stage.
// Reset clears all stage valid bits and returns the configuration to
// a 640 by 480 buffer with the scissor rectangle disabled.
`timescale 1ns / 1ps

module scissored_alpha_blend_pixel_write_top
    import sapw_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sapw_pixel_if.sink             pixel,
    sapw_result_if.source          result
);

    // Largest effective buffer dimension that a register can express.
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIMENSION > 8191) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIMENSION);

    // Configuration registers.
    logic [DIM_W-1:0]    buffer_width_reg;
    logic [DIM_W-1:0]    buffer_height_reg;
    logic                scissor_enable_reg;
    logic [EDGE_W-1:0]   scissor_left_reg;
    logic [EDGE_W-1:0]   scissor_top_reg;
    logic [EXTENT_W-1:0] scissor_width_reg;
    logic [EXTENT_W-1:0] scissor_height_reg;

    // Pipeline control.
    logic        valid1_reg;
    logic        valid2_reg;
    logic        valid3_reg;
    stage_load_t load;

    // Stage payloads.
    logic               keep1_reg;
    logic [DIM_W-1:0]   x1_reg;
    logic [DIM_W-1:0]   y1_reg;
    logic [DIM_W-1:0]   w1_reg;
    logic               keep2_reg;
    logic [INDEX_W-1:0] index2_reg;
    logic               keep3_reg;
    logic [INDEX_W-1:0] index3_reg;

    logic               keep1_next;
    logic [INDEX_W-1:0] index2_next;
    logic [INDEX_W-1:0] index3_next;

    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [14:0]         x_mag;
    logic [14:0]         y_mag;
    logic [14:0]         sc_right;
    logic [14:0]         sc_bottom;
    logic                in_buffer;
    logic                in_scissor;
    logic [2*DIM_W-1:0]  index_full;

    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_width_reg   <= BUFFER_WIDTH_RESET;
            buffer_height_reg  <= BUFFER_HEIGHT_RESET;
            scissor_enable_reg <= 1'b0;
            scissor_left_reg   <= '0;
            scissor_top_reg    <= '0;
            scissor_width_reg  <= '0;
            scissor_height_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BUFFER_WIDTH:   buffer_width_reg   <= cfg_data[DIM_W-1:0];
                REG_BUFFER_HEIGHT:  buffer_height_reg  <= cfg_data[DIM_W-1:0];
                REG_SCISSOR_ENABLE: scissor_enable_reg <= cfg_data[0];
                REG_SCISSOR_LEFT:   scissor_left_reg   <= cfg_data[EDGE_W-1:0];
                REG_SCISSOR_TOP:    scissor_top_reg    <= cfg_data[EDGE_W-1:0];
                REG_SCISSOR_WIDTH:  scissor_width_reg  <= cfg_data[EXTENT_W-1:0];
                REG_SCISSOR_HEIGHT: scissor_height_reg <= cfg_data[EXTENT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stall control: a stage loads when it is empty or its contents move on.
    always_comb
    begin
        load.load3 = !valid3_reg || result.ready;
        load.load2 = !valid2_reg || load.load3;
        load.load1 = !valid1_reg || load.load2;
    end

    assign pixel.ready = load.load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (load.load1)
            begin
                valid1_reg <= pixel.valid;
            end
            if (load.load2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (load.load3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    // Stage 1: buffer bounds, scissor test and transparent-source drop.
    always_comb
    begin
        w_eff     = (buffer_width_reg > DIM_CAP) ? DIM_CAP : buffer_width_reg;
        h_eff     = (buffer_height_reg > DIM_CAP) ? DIM_CAP : buffer_height_reg;
        x_mag     = pixel.data.pos_x[14:0];
        y_mag     = pixel.data.pos_y[14:0];
        sc_right  = 15'(scissor_left_reg) + 15'(scissor_width_reg);
        sc_bottom = 15'(scissor_top_reg) + 15'(scissor_height_reg);
        in_buffer = !pixel.data.pos_x[15] && !pixel.data.pos_y[15]
                    && (x_mag < 15'(w_eff)) && (y_mag < 15'(h_eff));
        in_scissor = (x_mag >= 15'(scissor_left_reg)) && (x_mag < sc_right)
                     && (y_mag >= 15'(scissor_top_reg)) && (y_mag < sc_bottom);
        keep1_next = (pixel.data.src_alpha != 8'd0) && in_buffer
                     && (!scissor_enable_reg || in_scissor);
    end

    // Stage 2: linear index y*width + x.
    always_comb
    begin
        index_full  = (2*DIM_W)'(y1_reg) * (2*DIM_W)'(w1_reg) + (2*DIM_W)'(x1_reg);
        index2_next = index_full[INDEX_W-1:0];
    end

    // Stage 3: dropped writes report a zero index.
    always_comb
    begin
        index3_next = keep2_reg ? index2_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load.load1)
        begin
            keep1_reg <= keep1_next;
            x1_reg    <= pixel.data.pos_x[DIM_W-1:0];
            y1_reg    <= pixel.data.pos_y[DIM_W-1:0];
            w1_reg    <= w_eff;
        end
        if (load.load2)
        begin
            keep2_reg  <= keep1_reg;
            index2_reg <= index2_next;
        end
        if (load.load3)
        begin
            keep3_reg  <= keep2_reg;
            index3_reg <= index3_next;
        end
    end

    // Per-channel blend lanes; an opaque source blends to itself exactly.
    sapw_blend_lane u_blue (
        .clk     (clk),
        .load    (load),
        .src     (pixel.data.src_blue),
        .dst     (pixel.data.dst_blue),
        .alpha   (pixel.data.src_alpha),
        .keep    (keep2_reg),
        .blended (blue_out)
    );

    sapw_blend_lane u_green (
        .clk     (clk),
        .load    (load),
        .src     (pixel.data.src_green),
        .dst     (pixel.data.dst_green),
        .alpha   (pixel.data.src_alpha),
        .keep    (keep2_reg),
        .blended (green_out)
    );

    sapw_blend_lane u_red (
        .clk     (clk),
        .load    (load),
        .src     (pixel.data.src_red),
        .dst     (pixel.data.dst_red),
        .alpha   (pixel.data.src_alpha),
        .keep    (keep2_reg),
        .blended (red_out)
    );

    // Result channel driven straight from the last stage.
    always_comb
    begin
        result.valid             = valid3_reg;
        result.data.write_enable = keep3_reg;
        result.data.pixel_index  = index3_reg;
        result.data.out_blue     = blue_out;
        result.data.out_green    = green_out;
        result.data.out_red      = red_out;
    end

endmodule

/* hw/rtl/sapw_blend_lane.sv */
// Three-stage source-over blend datapath for one color channel.
`timescale 1ns / 1ps

module sapw_blend_lane
    import sapw_pkg::*;
(
    input  logic        clk,
    input  stage_load_t load,
    input  logic [7:0]  src,
    input  logic [7:0]  dst,
    input  logic [7:0]  alpha,
    input  logic        keep,
    output logic [7:0]  blended
);

    logic [15:0] src_term_reg;
    logic [15:0] dst_term_reg;
    logic [15:0] sum_reg;
    logic [7:0]  blended_reg;

    logic [15:0] src_term_next;
    logic [15:0] dst_term_next;
    logic [15:0] sum_next;
    logic [31:0] scaled;
    logic [7:0]  blended_next;

    // Stage 1: weighted source and destination terms.
    always_comb
    begin
        src_term_next = 16'(src) * 16'(alpha);
        dst_term_next = 16'(dst) * 16'(ALPHA_FULL - alpha);
    end

    // Stage 2: rounded sum, at most 255*255+127.
    always_comb
    begin
        sum_next = src_term_reg + dst_term_reg + ROUND_BIAS;
    end

    // Stage 3: divide by 255 through the scaled reciprocal; dropped writes read zero.
    always_comb
    begin
        scaled       = 32'(sum_reg) * 32'(RECIP_255);
        blended_next = keep ? scaled[RECIP_SHIFT +: 8] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (load.load1)
        begin
            src_term_reg <= src_term_next;
            dst_term_reg <= dst_term_next;
        end
        if (load.load2)
        begin
            sum_reg <= sum_next;
        end
        if (load.load3)
        begin
            blended_reg <= blended_next;
        end
    end

    assign blended = blended_reg;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the scissored alpha blend pixel write unit.
`timescale 1ns / 1ps

import sapw_pkg::*;

// Tracks the register file, predicts each pixel write and checks the results in order.
class write_tracker;
    localparam int MAX_DIM = 4096;

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic                scissor_on;
    logic [EDGE_W-1:0]   left_reg;
    logic [EDGE_W-1:0]   top_reg;
    logic [EXTENT_W-1:0] clip_width;
    logic [EXTENT_W-1:0] clip_height;
    pixel_wr_t           pending_writes[$];
    int                  errors;
    int                  kept;
    int                  dropped;

    function new();
        width_reg   = BUFFER_WIDTH_RESET;
        height_reg  = BUFFER_HEIGHT_RESET;
        scissor_on  = 1'b0;
        left_reg    = '0;
        top_reg     = '0;
        clip_width  = '0;
        clip_height = '0;
        errors      = 0;
        kept        = 0;
        dropped     = 0;
    endfunction

    // Register writes are truncated to the register width; unknown indexes do nothing.
    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_BUFFER_WIDTH:   width_reg   = val[DIM_W-1:0];
            REG_BUFFER_HEIGHT:  height_reg  = val[DIM_W-1:0];
            REG_SCISSOR_ENABLE: scissor_on  = val[0];
            REG_SCISSOR_LEFT:   left_reg    = val[EDGE_W-1:0];
            REG_SCISSOR_TOP:    top_reg     = val[EDGE_W-1:0];
            REG_SCISSOR_WIDTH:  clip_width  = val[EXTENT_W-1:0];
            REG_SCISSOR_HEIGHT: clip_height = val[EXTENT_W-1:0];
            default: ;
        endcase
    endfunction

    // Buffer dimensions above the maximum behave as the maximum.
    function int effective(logic [DIM_W-1:0] dim);
        int d;
        d = dim;
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
        int si;
        int di;
        int ai;
        int sum;
        si  = s;
        di  = d;
        ai  = a;
        sum = si * ai + di * (255 - ai) + 127;
        return 8'(sum / 255);
    endfunction

    // Computes the write that one pixel request should produce.
    function pixel_wr_t blend_write_of(pixel_req_t req);
        pixel_wr_t wr;
        int        x;
        int        y;
        int        w;
        int        h;
        int        l;
        int        t;
        int        sw;
        int        sh;
        bit        keep;
        x    = $signed(req.pos_x);
        y    = $signed(req.pos_y);
        w    = effective(width_reg);
        h    = effective(height_reg);
        l    = left_reg;
        t    = top_reg;
        sw   = clip_width;
        sh   = clip_height;
        wr   = '0;
        keep = (req.src_alpha != 8'd0);
        if (x < 0 || y < 0 || x >= w || y >= h)
            keep = 1'b0;
        if (keep && scissor_on && (x < l || y < t || x >= l + sw || y >= t + sh))
            keep = 1'b0;
        if (keep)
        begin
            wr.write_enable = 1'b1;
            wr.pixel_index  = INDEX_W'(y * w + x);
            if (req.src_alpha == ALPHA_FULL)
            begin
                wr.out_blue  = req.src_blue;
                wr.out_green = req.src_green;
                wr.out_red   = req.src_red;
            end
            else
            begin
                wr.out_blue  = mix_channel(req.src_blue, req.dst_blue, req.src_alpha);
                wr.out_green = mix_channel(req.src_green, req.dst_green, req.src_alpha);
                wr.out_red   = mix_channel(req.src_red, req.dst_red, req.src_alpha);
            end
        end
        return wr;
    endfunction

    function void note_request(pixel_req_t req);
        pixel_wr_t wr;
        wr = blend_write_of(req);
        if (wr.write_enable)
            kept++;
        else
            dropped++;
        pending_writes.push_back(wr);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_write(pixel_wr_t got);
        pixel_wr_t want;
        if (pending_writes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
        end
        want = pending_writes.pop_front();
        compare_field("write_enable", want.write_enable, got.write_enable);
        compare_field("pixel_index", want.pixel_index, got.pixel_index);
        compare_field("out_blue", want.out_blue, got.out_blue);
        compare_field("out_green", want.out_green, got.out_green);
        compare_field("out_red", want.out_red, got.out_red);
    endfunction
endclass

module testbench;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   steady;
    logic                   hold_wanted;
    logic                   hold_done = 1'b0;
    int                     hold_left = 0;
    pixel_wr_t              seen;
    int                     items_sent;
    int                     settings_used;

    write_tracker tracker = new();

    sapw_pixel_if  pixel_ch ();
    sapw_result_if result_ch ();

    scissored_alpha_blend_pixel_write_top #(
        .MAX_DIMENSION(4096)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    // Run limit, far beyond the slowest passing run.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off on request, or always ready.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (hold_wanted && !hold_done)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= 80;
            hold_done       <= 1'b1;
        end
        else if (steady)
            result_ch.ready <= 1'b1;
        else
            result_ch.ready <= ($urandom_range(99) >= 35);
    end

    // Result monitor: sample between edges, check once the handshake edge has passed.
    always
    begin
        @(negedge clk);
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            seen = result_ch.data;
            @(posedge clk);
            tracker.check_write(seen);
        end
    end

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.set_register(idx, val);
        @(posedge clk);
    endtask

    // Writes the whole register file, optionally followed by a write to an unmapped index.
    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] l,
                             input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] sw,
                             input logic [CFG_DATA_W-1:0] sh, input bit poke_unused);
        put_reg(REG_BUFFER_WIDTH, w);
        put_reg(REG_BUFFER_HEIGHT, h);
        put_reg(REG_SCISSOR_ENABLE, en);
        put_reg(REG_SCISSOR_LEFT, l);
        put_reg(REG_SCISSOR_TOP, t);
        put_reg(REG_SCISSOR_WIDTH, sw);
        put_reg(REG_SCISSOR_HEIGHT, sh);
        if (poke_unused)
            put_reg(REG_UNUSED, '1);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offers one request and waits until the unit takes it.
    task automatic send_pixel(input pixel_req_t req);
        bit took;
        if (!steady)
        begin
            while ($urandom_range(99) < 35)
            begin
                pixel_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data  <= req;
        do
        begin
            @(negedge clk);
            took = (pixel_ch.ready === 1'b1);
            @(posedge clk);
        end
        while (!took);
        tracker.note_request(req);
        items_sent++;
    endtask

    task automatic send_at(input int x, input int y, input logic [7:0] a,
                           input logic [23:0] src, input logic [23:0] dst);
        pixel_req_t req;
        req.pos_x     = x[15:0];
        req.pos_y     = y[15:0];
        req.src_alpha = a;
        req.src_blue  = src[7:0];
        req.src_green = src[15:8];
        req.src_red   = src[23:16];
        req.dst_blue  = dst[7:0];
        req.dst_green = dst[15:8];
        req.dst_red   = dst[23:16];
        send_pixel(req);
    endtask

    // Coordinates cluster on the buffer interior, the buffer edges and the scissor edges.
    function automatic logic [15:0] pick_coord(int limit, int lo, int len);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 40)
            v = (limit > 0) ? $urandom_range(limit - 1, 0) : 0;
        else if (r < 60)
        begin
            case ($urandom_range(3))
                0:       v = -1;
                1:       v = 0;
                2:       v = limit - 1;
                default: v = limit;
            endcase
        end
        else if (r < 80)
        begin
            case ($urandom_range(3))
                0:       v = lo - 1;
                1:       v = lo;
                2:       v = lo + len - 1;
                default: v = lo + len;
            endcase
        end
        else
            v = $urandom;
        return v[15:0];
    endfunction

    task automatic send_random(input int count);
        pixel_req_t req;
        int         r;
        repeat (count)
        begin
            req.pos_x = pick_coord(tracker.effective(tracker.width_reg),
                                   tracker.left_reg, tracker.clip_width);
            req.pos_y = pick_coord(tracker.effective(tracker.height_reg),
                                   tracker.top_reg, tracker.clip_height);
            r = $urandom_range(99);
            if (r < 10)
                req.src_alpha = 8'd0;
            else if (r < 20)
                req.src_alpha = ALPHA_FULL;
            else if (r < 25)
                req.src_alpha = 8'd1;
            else if (r < 30)
                req.src_alpha = 8'd254;
            else
                req.src_alpha = $urandom_range(255);
            req.src_blue  = $urandom_range(255);
            req.src_green = $urandom_range(255);
            req.src_red   = $urandom_range(255);
            req.dst_blue  = $urandom_range(255);
            req.dst_green = $urandom_range(255);
            req.dst_red   = $urandom_range(255);
            send_pixel(req);
        end
    endtask

    // Stops offering and waits until every predicted write has come back.
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        while (tracker.pending_writes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.data  <= '0;
        steady         <= 1'b0;
        hold_wanted    <= 1'b0;
        items_sent     = 0;
        settings_used  = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset geometry: opaque, blended, transparent and off-buffer requests.
        send_at(0, 0, ALPHA_FULL, 24'hFFFFFF, 24'h000000);
        send_at(639, 479, 8'd1, 24'hFF80FF, 24'h00FF01);
        send_at(640, 0, 8'd128, 24'h123456, 24'h654321);
        send_at(0, 480, 8'd128, 24'h123456, 24'h654321);
        send_at(-1, 0, ALPHA_FULL, 24'hAAAAAA, 24'h555555);
        send_at(0, -1, ALPHA_FULL, 24'hAAAAAA, 24'h555555);
        send_at(-32768, 32767, ALPHA_FULL, 24'h0F0F0F, 24'hF0F0F0);
        send_at(32767, -32768, ALPHA_FULL, 24'h0F0F0F, 24'hF0F0F0);
        send_at(10, 10, 8'd0, 24'hFFFFFF, 24'hFFFFFF);
        send_at(5, 5, 8'd254, 24'h000000, 24'hFFFFFF);
        send_at(6, 5, 8'd127, 24'hFFFFFF, 24'h000000);

        // Random traffic with one long stall on the result side.
        hold_wanted <= 1'b1;
        send_random(80);
        drain();

        // Oversized buffer and a scissor rectangle; probe just inside and outside each edge.
        configure(14'h3FFF, 14'h3FFF, 14'd1, 14'd100, 14'd50, 14'd200, 14'd100, 1'b1);
        send_at(99, 60, ALPHA_FULL, 24'h102030, 24'h000000);
        send_at(100, 50, ALPHA_FULL, 24'h102030, 24'h000000);
        send_at(299, 149, 8'd200, 24'h102030, 24'hC0B0A0);
        send_at(300, 60, ALPHA_FULL, 24'h102030, 24'h000000);
        send_at(150, 150, ALPHA_FULL, 24'h102030, 24'h000000);
        send_at(150, 49, ALPHA_FULL, 24'h102030, 24'h000000);
        send_at(4095, 4095, ALPHA_FULL, 24'h102030, 24'h000000);
        steady <= 1'b1;
        send_random(80);
        drain();
        steady <= 1'b0;

        // Smallest buffer; enable write carries only upper bits, so scissor stays off.
        configure(14'd1, 14'd1, 14'h3FFE, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b0);
        send_random(60);
        drain();

        // Largest buffer with a scissor that leaves only the far corner.
        configure(14'h1000, 14'h1000, 14'd1, 14'd4095, 14'd4095, 14'h3FFF, 14'h3FFF, 1'b0);
        send_at(4095, 4095, 8'd77, 24'h00FF00, 24'hFF00FF);
        send_at(4094, 4095, ALPHA_FULL, 24'h00FF00, 24'hFF00FF);
        send_random(60);
        drain();

        // Zero buffer width drops every write.
        configure(14'd0, 14'd100, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 1'b0);
        send_at(0, 0, ALPHA_FULL, 24'hFFFFFF, 24'h000000);
        send_random(40);
        drain();

        // Zero scissor width clips everything.
        configure(14'd333, 14'd77, 14'd1, 14'd0, 14'd0, 14'd0, 14'd8192, 1'b0);
        send_at(0, 0, ALPHA_FULL, 24'hFFFFFF, 24'h000000);
        send_random(40);
        drain();

        // Wide and thin scissor band on an odd-sized buffer.
        configure(14'd1000, 14'd4095, 14'd1, 14'd17, 14'd3, 14'd8192, 14'd9, 1'b0);
        send_random(100);
        drain();

        // Small scissor rectangle starting at the buffer center on the default geometry.
        configure(14'd640, 14'd480, 14'd1, 14'd320, 14'd240, 14'd64, 14'd48, 1'b0);
        send_random(100);
        drain();

        $display("Ran %0d pixel requests over %0d register settings: %0d written, %0d dropped.",
                 items_sent, settings_used, tracker.kept, tracker.dropped);
        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* scissored_alpha_blend_pixel_write_top.f */
hw/rtl/sapw_pkg.sv
hw/rtl/sapw_pixel_if.sv
hw/rtl/sapw_result_if.sv
hw/rtl/sapw_blend_lane.sv
hw/rtl/scissored_alpha_blend_pixel_write_top.sv
verif/testbench.sv
